### design/slc_pkg.sv
// Shared types, character codes and line class codes for the source line classifier.
// No dependencies; imported by slc_rules and source_line_classifier_unit.
package slc_pkg;

   localparam int COUNT_WIDTH    = 32;
   localparam int OUT_WIDTH      = 32;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 136;

   localparam logic [15:0] CH_NL    = 16'h000A;
   localparam logic [15:0] CH_SP    = 16'h0020;
   localparam logic [15:0] CH_QUOTE = 16'h0022;
   localparam logic [15:0] CH_BSL   = 16'h005C;
   localparam logic [15:0] CH_SLASH = 16'h002F;
   localparam logic [15:0] CH_STAR  = 16'h002A;

   localparam logic [1:0] CLASS_NONE    = 2'd0;
   localparam logic [1:0] CLASS_BLANK   = 2'd1;
   localparam logic [1:0] CLASS_COMMENT = 2'd2;
   localparam logic [1:0] CLASS_CODE    = 2'd3;

   typedef struct packed {
      logic skip;
      logic code;
      logic sl2;
      logic sl1;
      logic esc;
      logic str;
      logic blank;
   } line_flags_type;

   typedef struct packed {
      logic closed;
      logic star;
      logic in_comment;
   } block_flags_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Low OUT_WIDTH bits of a counter, zero-extended when the counter is narrower.
   function automatic logic [OUT_WIDTH-1:0] count_out(input count_type c);
      logic [COUNT_WIDTH+OUT_WIDTH-1:0] wide;
      wide = {{OUT_WIDTH{1'b0}}, c};
      return wide[OUT_WIDTH-1:0];
   endfunction

   function automatic count_type sat_inc(input count_type c);
      return (c == {COUNT_WIDTH{1'b1}}) ? c : c + count_type'(1);
   endfunction

endpackage

### design/source_line_classifier_unit.sv
// Top level of the source line classifier: input register, flag/counter state, result register.
// Depends on slc_pkg and slc_rules.
//
// Usage:
//   req channel: one character per item. req_tdata[15:0] is the 16-bit code unit,
//   req_tlast marks the last character of the text.
//   rsp channel: one item per ended line (newline or last character). rsp_tdata
//   carries the line class and the four running totals; rsp_tlast marks the line
//   that ended the text, whose totals are final.
// Path: the accepting edge loads the input register; the line result is loaded from there
//   into the result register once that register is free.
// Throughput: one character per cycle, except while a line-ending character waits for the
//   output register (see Stall). The flag and counter update is a single pass of rule
//   logic and one saturating increment per counter, looping through the state registers.
// Stall: while a result waits in the output register, characters that end no line
//   still advance; a character that ends a line holds in the input register until
//   the output register frees, and req_tready drops only then.
// Reset: synchronous, active high; clears all flags, counters and valid bits.
//   After the last character of a text the flags and counters return to that state.
module source_line_classifier_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [slc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,   // [15:0] char_code
   input  logic                               req_tlast,   // end_of_text
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] line_class, [33:2] line_count, [65:34] blank_count,
   // [97:66] comment_count, [129:98] code_count, [135:130] zero
   output logic [slc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast    // final_line
);
   import slc_pkg::*;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_char_ff;
   logic        in_last_ff;

   // Flag and counter state
   line_flags_type  line_ff, line_in;
   block_flags_type block_ff, block_in;
   count_type       total_ff, total_in;
   count_type       blank_ff, blank_in;
   count_type       comment_ff, comment_in;
   count_type       code_ff, code_in;

   // Result register
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                      out_last_ff;

   line_flags_type  line_nxt;
   block_flags_type block_nxt;
   logic [1:0]      line_class;
   logic            line_end;
   logic            out_free;
   logic            advance;
   logic            load_out;

   slc_rules u_rules (
      .char_code  (in_char_ff),
      .line_cur   (line_ff),
      .block_cur  (block_ff),
      .line_nxt   (line_nxt),
      .block_nxt  (block_nxt),
      .line_class (line_class)
   );

   assign line_end = (in_char_ff == CH_NL) || in_last_ff;
   assign out_free = !out_valid_ff || rsp_tready;
   // A character that ends no line never needs the output register.
   assign advance  = in_valid_ff && (out_free || !line_end);
   assign load_out = advance && line_end;

   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_comb begin
      line_in    = line_ff;
      block_in   = block_ff;
      total_in   = total_ff;
      blank_in   = blank_ff;
      comment_in = comment_ff;
      code_in    = code_ff;
      if (advance) begin
         line_in  = line_nxt;
         block_in = block_nxt;
         if (line_end) begin
            total_in = sat_inc(total_ff);
            case (line_class)
               CLASS_BLANK:   blank_in   = sat_inc(blank_ff);
               CLASS_COMMENT: comment_in = sat_inc(comment_ff);
               CLASS_CODE:    code_in    = sat_inc(code_ff);
               default:       ;
            endcase
            // Line flags restart on every line; the rest only at end of text.
            line_in = '0;
         end
      end
   end

   assign out_data_in = {{(RSP_DATA_WIDTH - 2 - 4*OUT_WIDTH){1'b0}},
                         count_out(code_in), count_out(comment_in),
                         count_out(blank_in), count_out(total_in), line_class};
   assign out_valid_in = load_out || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         line_ff      <= '0;
         block_ff     <= '0;
         total_ff     <= '0;
         blank_ff     <= '0;
         comment_ff   <= '0;
         code_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_last_ff) begin
            // End of text: drop all state back to reset.
            line_ff    <= '0;
            block_ff   <= '0;
            total_ff   <= '0;
            blank_ff   <= '0;
            comment_ff <= '0;
            code_ff    <= '0;
         end else begin
            line_ff    <= line_in;
            block_ff   <= block_in;
            total_ff   <= total_in;
            blank_ff   <= blank_in;
            comment_ff <= comment_in;
            code_ff    <= code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata[15:0];
         in_last_ff <= req_tlast;
      end
      if (load_out) begin
         out_data_ff <= out_data_in;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // Per-class counters can never pass the line counter.
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      blank_ff <= total_ff && comment_ff <= total_ff && code_ff <= total_ff)
      else $error("class counter exceeds line counter");

   // A star inside a block comment is only tracked while inside it.
   a_star_inside: assert property (@(posedge clock) disable iff (reset)
      block_ff.star |-> block_ff.in_comment)
      else $error("star flag set outside block comment");

   // Skip to end of line only follows a second slash.
   a_skip_sl2: assert property (@(posedge clock) disable iff (reset)
      line_ff.skip |-> line_ff.sl2)
      else $error("skip flag without second slash");

   // After the last line of a text the state is back at reset.
   a_text_end_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (total_ff == '0 && block_ff == '0 && line_ff == '0))
      else $error("state not cleared after end of text");

   // A result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !load_out)
      else $error("result register overwritten while stalled");

endmodule

### design/slc_rules.sv
// Flag update rules for one character and the line class of the updated flags.
// Depends on slc_pkg.
module slc_rules (
   input  logic [15:0]              char_code,
   input  slc_pkg::line_flags_type  line_cur,
   input  slc_pkg::block_flags_type block_cur,
   output slc_pkg::line_flags_type  line_nxt,
   output slc_pkg::block_flags_type block_nxt,
   output logic [1:0]               line_class
);
   import slc_pkg::*;

   logic s1, s2, cin, cst, cdn, str, code;

   assign s1   = line_cur.sl1;
   assign s2   = line_cur.sl2;
   assign str  = line_cur.str;
   assign code = line_cur.code;
   assign cin  = block_cur.in_comment;
   assign cst  = block_cur.star;
   assign cdn  = block_cur.closed;

   // First matching rule wins; a skipped line holds every flag.
   always_comb begin
      line_nxt  = line_cur;
      block_nxt = block_cur;
      if (line_cur.skip) begin
         line_nxt = line_cur;
      end else if (char_code >= CH_SP) begin
         if (char_code == CH_SP && !s1 && !s2 && !code && !cin && !cst) begin
            line_nxt.blank = 1'b1;
         end else if (char_code == CH_QUOTE && !s1 && !cin && !cst && !str) begin
            line_nxt.blank = 1'b0;
            line_nxt.str   = 1'b1;
         end else if (char_code == CH_BSL && !s1 && !cin && !cst && str) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b1;
         end else if (char_code == CH_QUOTE && !s1 && !cin && !cst && str) begin
            line_nxt.blank = 1'b0;
            if (!line_cur.esc) line_nxt.str = 1'b0;
            else               line_nxt.esc = 1'b0;
         end else if (char_code == CH_SLASH && !str && !s1 && !cin && !cst) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b0;
            line_nxt.sl1   = 1'b1;
         end else if (char_code == CH_SLASH && !str && s1 && !s2 && !cin && !cst) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b0;
            line_nxt.sl2   = 1'b1;
            if (!code) line_nxt.skip = 1'b1;
         end else if (char_code == CH_SLASH && !str && !s1 && !s2 && cin && cst) begin
            line_nxt.blank       = 1'b0;
            line_nxt.esc         = 1'b0;
            block_nxt.in_comment = 1'b0;
            block_nxt.star       = 1'b0;
            block_nxt.closed     = 1'b1;
         end else if (char_code == CH_STAR && !str && s1 && !s2 && !cin && !cst) begin
            line_nxt.blank       = 1'b0;
            line_nxt.esc         = 1'b0;
            line_nxt.sl1         = 1'b0;
            block_nxt.in_comment = 1'b1;
         end else if (char_code == CH_STAR && !str && !s1 && !s2 && cin && !cst) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b0;
            block_nxt.star = 1'b1;
         end else if (!s1 && !s2 && cin && cst && !cdn) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b0;
            block_nxt.star = 1'b0;
            line_nxt.code  = 1'b1;
         end else if (char_code > CH_SP && !s1 && !s2 && !code && !cin && !cst && !cdn) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b0;
            line_nxt.code  = 1'b1;
         end else if (char_code > CH_SP && !s1 && !s2 && !code && !cin && !cst && cdn) begin
            line_nxt.blank   = 1'b0;
            line_nxt.esc     = 1'b0;
            block_nxt.closed = 1'b0;
            line_nxt.code    = 1'b1;
         end else if (char_code == CH_SP && !s1 && !s2 && !code && !cin && !cst && cdn) begin
            line_nxt.blank = 1'b0;
            line_nxt.esc   = 1'b0;
         end
      end else begin
         if (!s1 && !s2 && !code && !cin && !cst && !cdn) line_nxt.blank = 1'b1;
      end
   end

   // Class of the line as the flags stand after this character.
   always_comb begin
      if (line_nxt.blank && !line_nxt.sl1 && !line_nxt.sl2 && !line_nxt.code &&
          !block_nxt.in_comment && !block_nxt.star) begin
         line_class = CLASS_BLANK;
      end else if (line_nxt.code) begin
         line_class = CLASS_CODE;
      end else if (!line_nxt.blank && line_nxt.sl1 && line_nxt.sl2 &&
                   !block_nxt.in_comment && !block_nxt.star) begin
         line_class = CLASS_COMMENT;
      end else if (block_nxt.in_comment && !block_nxt.star && !block_nxt.closed) begin
         line_class = CLASS_COMMENT;
      end else if (block_nxt.closed) begin
         line_class = CLASS_COMMENT;
      end else begin
         line_class = CLASS_NONE;
      end
   end

endmodule

### dv/tb_source_line_classifier_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_line_classifier_unit: streams C-like text, predicts
// each line's class and running totals, and compares every rsp item. Depends on slc_pkg.
module tb_source_line_classifier_unit;
   import slc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_CHARS  = 375;
   localparam int TAIL_CYCLES  = 10;

   typedef struct {
      logic [15:0] code;
      logic        last;
   } text_char_type;

   typedef struct {
      logic [1:0]  line_class;
      logic [31:0] lines;
      logic [31:0] blanks;
      logic [31:0] comments;
      logic [31:0] codes;
      logic        final_line;
   } line_report_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;   // [15:0] char_code
   logic                      req_tlast = 1'b0; // end_of_text
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [1:0] line_class, [33:2] line_count, [65:34] blank_count,
   // [97:66] comment_count, [129:98] code_count, [135:130] zero
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;        // final_line

   // Characters waiting to be driven, and line results waiting to arrive.
   text_char_type   char_queue[$];
   line_report_type line_reports_due[$];
   text_char_type   next_char;
   // Characters put on the bus by the driver and taken by the block.
   int unsigned     sent_count = 0;
   int unsigned     taken_count = 0;

   // Idle and stall odds, in percent, for the current phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned phase_chars;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Shadow of the block's state.
   line_flags_type  cur_line = '0;
   block_flags_type cur_block = '0;
   count_type       total_lines = '0;
   count_type       blank_lines = '0;
   count_type       comment_lines = '0;
   count_type       code_lines = '0;

   source_line_classifier_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Saturating counter step: hold at all ones.
   function automatic count_type bump(input count_type c);
      if (&c) return c;
      return c + count_type'(1);
   endfunction

   // Advance the shadow state by one character; queue a line result when a line ends.
   task automatic classify_char(input logic [15:0] ch, input logic last);
      line_flags_type  lf;
      block_flags_type bf;
      logic [1:0]      cls;
      line_report_type rep;
      lf = cur_line;
      bf = cur_block;
      // Once a line comment has started on a line with no code before it, the rest of the line changes no flag.
      if (!lf.skip) begin
         if (ch >= CH_SP) begin
            if (ch == CH_SP && !lf.sl1 && !lf.sl2 && !lf.code && !bf.in_comment
                && !bf.star) begin
               lf.blank = 1'b1;
            end else if (ch == CH_QUOTE && !lf.sl1 && !bf.in_comment && !bf.star
                         && !lf.str) begin
               lf.blank = 1'b0;
               lf.str   = 1'b1;
            end else if (ch == CH_BSL && !lf.sl1 && !bf.in_comment && !bf.star && lf.str) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b1;
            end else if (ch == CH_QUOTE && !lf.sl1 && !bf.in_comment && !bf.star
                         && lf.str) begin
               // Escaped quote stays inside the string and consumes the escape.
               lf.blank = 1'b0;
               if (!lf.esc) lf.str = 1'b0;
               else lf.esc = 1'b0;
            end else if (ch == CH_SLASH && !lf.str && !lf.sl1 && !bf.in_comment
                         && !bf.star) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b0;
               lf.sl1   = 1'b1;
            end else if (ch == CH_SLASH && !lf.str && lf.sl1 && !lf.sl2 && !bf.in_comment
                         && !bf.star) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b0;
               lf.sl2   = 1'b1;
               if (!lf.code) lf.skip = 1'b1;
            end else if (ch == CH_SLASH && !lf.str && !lf.sl1 && !lf.sl2 && bf.in_comment
                         && bf.star) begin
               lf.blank      = 1'b0;
               lf.esc        = 1'b0;
               bf.in_comment = 1'b0;
               bf.star       = 1'b0;
               bf.closed     = 1'b1;
            end else if (ch == CH_STAR && !lf.str && lf.sl1 && !lf.sl2 && !bf.in_comment
                         && !bf.star) begin
               lf.blank      = 1'b0;
               lf.esc        = 1'b0;
               lf.sl1        = 1'b0;
               bf.in_comment = 1'b1;
            end else if (ch == CH_STAR && !lf.str && !lf.sl1 && !lf.sl2 && bf.in_comment
                         && !bf.star) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b0;
               bf.star  = 1'b1;
            end else if (!lf.sl1 && !lf.sl2 && bf.in_comment && bf.star && !bf.closed) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b0;
               bf.star  = 1'b0;
               lf.code  = 1'b1;
            end else if (ch > CH_SP && !lf.sl1 && !lf.sl2 && !lf.code && !bf.in_comment
                         && !bf.star && !bf.closed) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b0;
               lf.code  = 1'b1;
            end else if (ch > CH_SP && !lf.sl1 && !lf.sl2 && !lf.code && !bf.in_comment
                         && !bf.star && bf.closed) begin
               lf.blank  = 1'b0;
               lf.esc    = 1'b0;
               bf.closed = 1'b0;
               lf.code   = 1'b1;
            end else if (ch == CH_SP && !lf.sl1 && !lf.sl2 && !lf.code && !bf.in_comment
                         && !bf.star && bf.closed) begin
               lf.blank = 1'b0;
               lf.esc   = 1'b0;
            end
         end else if (!lf.sl1 && !lf.sl2 && !lf.code && !bf.in_comment && !bf.star
                      && !bf.closed) begin
            // Control characters, newline among them, only mark the line blank.
            lf.blank = 1'b1;
         end
      end
      cur_line  = lf;
      cur_block = bf;
      if (ch == CH_NL || last) begin
         if (lf.blank && !lf.sl1 && !lf.sl2 && !lf.code && !bf.in_comment && !bf.star)
            cls = CLASS_BLANK;
         else if (lf.code)
            cls = CLASS_CODE;
         else if (!lf.blank && lf.sl1 && lf.sl2 && !bf.in_comment && !bf.star)
            cls = CLASS_COMMENT;
         else if (bf.in_comment && !bf.star && !bf.closed)
            cls = CLASS_COMMENT;
         else if (bf.closed)
            cls = CLASS_COMMENT;
         else
            cls = CLASS_NONE;
         total_lines = bump(total_lines);
         case (cls)
            CLASS_BLANK:   blank_lines   = bump(blank_lines);
            CLASS_COMMENT: comment_lines = bump(comment_lines);
            CLASS_CODE:    code_lines    = bump(code_lines);
            default: ;
         endcase
         rep.line_class = cls;
         rep.lines      = 32'(total_lines);
         rep.blanks     = 32'(blank_lines);
         rep.comments   = 32'(comment_lines);
         rep.codes      = 32'(code_lines);
         rep.final_line = last;
         line_reports_due = {line_reports_due, rep};
         cur_line = '0;
         // End of text clears everything, block comment state and totals too.
         if (last) begin
            cur_block     = '0;
            total_lines   = '0;
            blank_lines   = '0;
            comment_lines = '0;
            code_lines    = '0;
         end
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic push_char(input logic [15:0] code, input logic last);
      text_char_type c;
      c.code = code;
      c.last = last;
      char_queue = {char_queue, c};
      phase_chars++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(16'(s[i]), 1'b0);
   endtask

   // Draw one character, weighted toward the ones that move the flags.
   function automatic logic [15:0] pick_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) return 16'($urandom_range(16'h21, 16'h7E));
      if (r < 42) return CH_SP;
      if (r < 55) return CH_SLASH;
      if (r < 65) return CH_STAR;
      if (r < 73) return CH_QUOTE;
      if (r < 78) return CH_BSL;
      if (r < 83) return 16'($urandom_range(0, 16'h1F));
      if (r < 93) return 16'($urandom_range(16'h80, 16'hFFFF));
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // One text: several lines of C-like content, or now and then raw noise.
   task automatic push_random_text();
      logic [15:0] line_buf[$];
      int unsigned n_lines;
      int unsigned len;
      if ($urandom_range(99) < 6) begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            push_char(16'($urandom_range(0, 16'hFFFF)), i == len - 1);
         return;
      end
      n_lines = $urandom_range(1, 10);
      for (int l = 0; l < n_lines; l++) begin
         line_buf.delete();
         len = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
         for (int i = 0; i < len; i++) line_buf = {line_buf, pick_char()};
         for (int i = 0; i < line_buf.size(); i++) begin
            // Sometimes end the text on the line's last character, without a newline.
            push_char(line_buf[i], (l == n_lines - 1) && (i == line_buf.size() - 1)
                                   && (len[0] == 1'b1));
         end
         if (!((l == n_lines - 1) && len[0] == 1'b1)) push_char(CH_NL, l == n_lines - 1);
      end
   endtask

   // Hold until every character is accepted and every line result has arrived.
   task automatic wait_drained();
      do @(negedge clock);
      while (!(char_queue.size() == 0 && taken_count == sent_count
               && line_reports_due.size() == 0));
      @(posedge clock);
   endtask

   // Driver: advance to the next character once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || taken_count == sent_count) begin
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_char = char_queue.pop_front();
               sent_count++;
               req_tdata  <= next_char.code;
               req_tlast  <= next_char.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: check results first, then predict from the accepted character.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (line_reports_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[33:2], 32'd0);
            end else begin
               line_report_type want;
               want = line_reports_due.pop_front();
               if (rsp_tdata[1:0] !== want.line_class)
                  report_mismatch("line_class", 32'(rsp_tdata[1:0]), 32'(want.line_class));
               if (rsp_tdata[33:2] !== want.lines)
                  report_mismatch("line_count", rsp_tdata[33:2], want.lines);
               if (rsp_tdata[65:34] !== want.blanks)
                  report_mismatch("blank_count", rsp_tdata[65:34], want.blanks);
               if (rsp_tdata[97:66] !== want.comments)
                  report_mismatch("comment_count", rsp_tdata[97:66], want.comments);
               if (rsp_tdata[129:98] !== want.codes)
                  report_mismatch("code_count", rsp_tdata[129:98], want.codes);
               if (rsp_tdata[135:130] !== '0)
                  report_mismatch("pad bits", 32'(rsp_tdata[135:130]), 32'd0);
               if (rsp_tlast !== want.final_line)
                  report_mismatch("final_line", 32'(rsp_tlast), 32'(want.final_line));
            end
         end
         if (req_tvalid && req_tready) begin
            classify_char(req_tdata[15:0], req_tlast);
            taken_count++;
         end
      end
   end

   // Watchdog: end the run once cycle_count passes CYCLE_LIMIT, progress or not.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: blank line, code with an escaped quote in a string, line comment
      // with a high code inside, block comment across two lines, then a NUL and
      // an end of text on a character above 0x7F.
      phase_chars = 0;
      push_text(" \n");
      push_text("a\"\\\"\"\n");
      push_text("//");
      push_char(16'hFFFF, 1'b0);
      push_char(CH_NL, 1'b0);
      push_text("/*\n");
      push_text("*/\n");
      push_char(16'h0000, 1'b0);
      push_char(16'h8000, 1'b1);
      wait_drained();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) push_random_text();
         // Drain fully before the next phase so that every result of this phase has arrived.
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (line_reports_due.size() != 0)
         report_mismatch("results never arrived", 32'(line_reports_due.size()), 32'd0);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
